// File: rtl/lbp_pkg.sv
// ============================================================================
// lbp_pkg
// Shared types and constants for the lattice best-path core.
// ============================================================================
`default_nettype none

package lbp_pkg;

    localparam int POS_W       = 6;
    localparam int WORD_W      = 16;
    localparam int COST_W      = 15;
    localparam int ACC_W       = 24;
    localparam int CFG_W       = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int RESULT_CAP  = 32;
    localparam int CNT_W       = $clog2(RESULT_CAP);
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    localparam logic [ACC_W-1:0]  ACC_MAX            = '1;
    localparam logic [POS_W-1:0]  RST_SENT_LEN       = 6'd32;
    localparam logic [COST_W-1:0] RST_WORD_PENALTY   = 15'd6803;
    localparam logic [COST_W-1:0] RST_COST_CEILING   = 15'd25513;

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [ACC_W-1:0]  cost;
        t_pos              start;
        logic [WORD_W-1:0] word;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENT_LEN     = 2'd0,
        CFG_WORD_PENALTY = 2'd1,
        CFG_COST_CEILING = 2'd2
    } t_cfg_idx;

    // position store command
    typedef struct packed {
        t_pos   rd_a;
        t_pos   rd_b;
        logic   wr_en;
        t_pos   wr_pos;
        t_entry wr_data;
        logic   clear;
    } t_store_cmd;

endpackage

`default_nettype wire

// File: rtl/lattice_best_path_core.sv
// ============================================================================
// lattice_best_path_core
// Best path through a word lattice, Viterbi relaxation over positions.
// ============================================================================
// Edge transactions (tuser 0) are accepted in ST_IDLE, which reads the start
// and end entries of the position RAM; ST_RELAX then relaxes and writes back.
// A finish transaction (tuser 1) walks the backpointers from the sentence
// length: each emitted word takes a RAM read (ST_WALK_RD), then an output
// register load (ST_WALK_EMIT) that waits while the output side stalls; a
// not-found or empty-path result is loaded from ST_ONE. The store is cleared
// in the cycle the last result is loaded.
// Results go out last word first; tuser carries found, tlast the final one.
`default_nettype none

module lattice_best_path_core #(
    parameter int MAX_POSITIONS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [lbp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lbp_pkg::CFG_W-1:0]         i_cfg_data,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // start_position, end_position, word_id, edge_cost
    input  wire logic [lbp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func
    input  wire logic                              s_axis_tuser,
    // output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // path_word, word_start, word_end, total_cost
    output logic [lbp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // found
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast
);

    import lbp_pkg::*;

    localparam int   AW      = $clog2(MAX_POSITIONS + 1);
    localparam t_pos MAX_POS = POS_W'(MAX_POSITIONS);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_RELAX     = 5'b00010,
        ST_WALK_RD   = 5'b00100,
        ST_WALK_EMIT = 5'b01000,
        ST_ONE       = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration
    t_pos              r_sent_len;
    logic [COST_W-1:0] r_word_penalty;
    logic [COST_W-1:0] r_cost_ceiling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_len     <= RST_SENT_LEN;
            r_word_penalty <= RST_WORD_PENALTY;
            r_cost_ceiling <= RST_COST_CEILING;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SENT_LEN:     r_sent_len     <= i_cfg_data[POS_W-1:0];
                CFG_WORD_PENALTY: r_word_penalty <= i_cfg_data;
                CFG_COST_CEILING: r_cost_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input fields
    t_pos              in_start, in_end;
    logic [WORD_W-1:0] in_word;
    logic [COST_W-1:0] in_cost;

    assign in_start = s_axis_tdata[5:0];
    assign in_end   = s_axis_tdata[11:6];
    assign in_word  = s_axis_tdata[27:12];
    assign in_cost  = s_axis_tdata[42:28];

    // store
    t_store_cmd             cmd;
    t_entry                 rd_a, rd_b;
    logic [MAX_POSITIONS:0] reached;

    lbp_store #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b),
        .o_reached (reached)
    );

    // edge context
    logic              r_do;
    logic              r_reach_e;
    t_pos              r_s, r_e;
    logic [WORD_W-1:0] r_w;
    logic [COST_W:0]   r_inc;
    // walk context
    t_pos              r_p;
    logic [CNT_W-1:0]  r_n;
    logic [ACC_W-1:0]  r_total;
    logic              r_one_found;
    // output register
    logic              r_ov;
    logic              r_o_found;
    logic [WORD_W-1:0] r_o_word;
    t_pos              r_o_start, r_o_end;
    logic [ACC_W-1:0]  r_o_cost;
    logic              r_o_last;

    logic              accept, out_free;
    logic              in_ok, s_reached, e_reached, t_reached;
    logic [COST_W-1:0] c_lim;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  nc;
    logic              upd;
    logic [ACC_W-1:0]  walk_total;
    logic              walk_fin;
    logic              load_walk, load_one;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;

    assign in_ok     = (in_start <= MAX_POS) && (in_end <= MAX_POS) && (in_end > in_start);
    assign s_reached = (in_start <= MAX_POS) && reached[in_start[AW-1:0]];
    assign e_reached = (in_end <= MAX_POS) && reached[in_end[AW-1:0]];
    assign t_reached = (r_sent_len <= MAX_POS) && reached[r_sent_len[AW-1:0]];
    assign c_lim     = (in_cost > r_cost_ceiling) ? r_cost_ceiling : in_cost;

    assign sum = {1'b0, rd_a.cost} + (ACC_W + 1)'(r_inc);
    assign nc  = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    assign upd = r_do && (!r_reach_e || (nc < rd_b.cost));

    assign walk_total = (r_n == '0) ? rd_a.cost : r_total;
    assign walk_fin   = (rd_a.start == '0) || (rd_a.start >= r_p)
                     || (r_n == CNT_W'(RESULT_CAP - 1));
    assign load_walk  = (r_state == ST_WALK_EMIT) && out_free;
    assign load_one   = (r_state == ST_ONE) && out_free;

    always_comb begin
        cmd              = '0;
        cmd.rd_a         = in_start;
        cmd.rd_b         = in_end;
        cmd.wr_pos       = r_e;
        cmd.wr_data.cost  = nc;
        cmd.wr_data.start = r_s;
        cmd.wr_data.word  = r_w;
        n_state          = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_axis_tuser) begin
                        n_state = ST_RELAX;
                    end else if (t_reached && (r_sent_len != '0)) begin
                        n_state = ST_WALK_RD;
                    end else begin
                        n_state = ST_ONE;
                    end
                end
            end
            ST_RELAX: begin
                cmd.wr_en = upd;
                n_state   = ST_IDLE;
            end
            ST_WALK_RD: begin
                cmd.rd_a = r_p;
                n_state  = ST_WALK_EMIT;
            end
            ST_WALK_EMIT: begin
                cmd.rd_a = r_p;
                if (out_free) begin
                    cmd.clear = walk_fin;
                    n_state   = walk_fin ? ST_IDLE : ST_WALK_RD;
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    cmd.clear = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_walk || load_one) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_do        <= in_ok && s_reached && !((in_start == '0) && (in_end == r_sent_len));
            r_reach_e   <= e_reached;
            r_s         <= in_start;
            r_e         <= in_end;
            r_w         <= in_word;
            r_inc       <= {1'b0, c_lim} + {1'b0, r_word_penalty};
            r_p         <= r_sent_len;
            r_n         <= '0;
            r_one_found <= t_reached;
        end
        if (load_walk) begin
            r_total   <= walk_total;
            r_n       <= r_n + CNT_W'(1);
            r_p       <= rd_a.start;
            r_o_found <= 1'b1;
            r_o_word  <= rd_a.word;
            r_o_start <= rd_a.start;
            r_o_end   <= r_p;
            r_o_cost  <= walk_total;
            r_o_last  <= walk_fin;
        end else if (load_one) begin
            r_o_found <= r_one_found;
            r_o_word  <= '0;
            r_o_start <= '0;
            r_o_end   <= '0;
            r_o_cost  <= '0;
            r_o_last  <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'b0, r_o_cost, r_o_end, r_o_start, r_o_word};
    assign m_axis_tuser  = r_o_found;
    assign m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire

// File: rtl/lbp_ram.sv
// ============================================================================
// lbp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
`default_nettype none

module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// File: rtl/lbp_store.sv
// ============================================================================
// lbp_store
// Per-position state: entry RAM plus reached bits; position zero reads as
// zero. Clear resets the reached bits, leaving only position zero reached.
// ============================================================================
`default_nettype none

module lbp_store #(
    parameter int MAX_POSITIONS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire lbp_pkg::t_store_cmd    i_cmd,
    output lbp_pkg::t_entry             o_rdata_a,
    output lbp_pkg::t_entry             o_rdata_b,
    output logic [MAX_POSITIONS:0]      o_reached
);

    import lbp_pkg::*;

    localparam int NPOS = MAX_POSITIONS + 1;
    localparam int AW   = $clog2(NPOS);

    logic [NPOS-1:0]    r_reached;
    logic               r_a_zero;
    logic               r_b_zero;
    logic [ENTRY_W-1:0] ram_a;
    logic [ENTRY_W-1:0] ram_b;

    lbp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NPOS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.wr_en),
        .i_waddr   (i_cmd.wr_pos[AW-1:0]),
        .i_wdata   (i_cmd.wr_data),
        .i_raddr_a (i_cmd.rd_a[AW-1:0]),
        .o_rdata_a (ram_a),
        .i_raddr_b (i_cmd.rd_b[AW-1:0]),
        .o_rdata_b (ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_reached <= NPOS'(1);
        end else if (i_cmd.wr_en) begin
            r_reached[i_cmd.wr_pos[AW-1:0]] <= 1'b1;
        end
    end

    // position zero is never written; it always reads as cost zero
    always_ff @(posedge i_clk) begin
        r_a_zero <= (i_cmd.rd_a == '0);
        r_b_zero <= (i_cmd.rd_b == '0);
    end

    assign o_rdata_a = r_a_zero ? '0 : t_entry'(ram_a);
    assign o_rdata_b = r_b_zero ? '0 : t_entry'(ram_b);
    assign o_reached = r_reached;

endmodule

`default_nettype wire
